// ===== rtl/core/mlpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlpp_pkg
// Request and result types and command codes of the LED pattern player.
// ----------------------------------------------------------------------------
package mlpp_pkg;

  localparam int CMD_W   = 3;
  localparam int CHAN_W  = 5;
  localparam int WIDX_W  = 10;
  localparam int DUTY_W  = 16;
  localparam int LEN_W   = 11;
  localparam int IVL_W   = 16;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LENGTH   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INTERVAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUTY     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [WIDX_W-1:0] word_index;
    logic [DUTY_W-1:0] pattern_word;
    logic [LEN_W-1:0]  seq_len;
    logic [IVL_W-1:0]  step_interval;
    logic [DUTY_W-1:0] duty_value;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [DUTY_W-1:0] out_duty;
    logic              last;
  } out_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/mlpp_state_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlpp_state_mem
// Per-channel state memory, one read and one write port, registered read.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module mlpp_state_mem #(
  parameter int DEPTH = 20,
  parameter int WIDTH = 64,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/mlpp_pattern_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlpp_pattern_mem
// Pattern word store for all channels, one read and one write port,
// registered read.
// ----------------------------------------------------------------------------
module mlpp_pattern_mem #(
  parameter int DEPTH = 20480,
  parameter int AW    = 15
) (
  input  wire logic                       clk,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output logic      [mlpp_pkg::DUTY_W-1:0] rdata,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [mlpp_pkg::DUTY_W-1:0] wdata
);
  import mlpp_pkg::*;

  logic [DUTY_W-1:0] mem [DEPTH];
  logic [DUTY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/multichannel_led_pattern_player.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_led_pattern_player
// Per-channel LED duty pattern player with a shared pattern store.
// ----------------------------------------------------------------------------
// One request is handled at a time. A pattern word write is done in idle; a
// length or interval setting passes through ST_CMD, a zero length through
// ST_CMD and ST_FLUSH, a direct duty setting through ST_FLUSH, the last two
// with any wait on the result side. A tick sweeps the channel state memory
// one channel at a time in ST_TRD, adds ST_TPAT for the pattern store read
// on each channel that steps, waiting there on the result side, and ends in
// ST_FLUSH. The single read port of the channel state memory sets the sweep
// rate. Results of a tick are held back by one so that the final one carries last.
// ----------------------------------------------------------------------------
module multichannel_led_pattern_player #(
  parameter int CHANNELS      = 20,
  parameter int PATTERN_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mlpp_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mlpp_pkg::out_res_t      out_data
);
  import mlpp_pkg::*;

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW     = $clog2(PATTERN_DEPTH + 1);
  localparam int PW     = $clog2(PATTERN_DEPTH);
  localparam int PINC_W = PW + 1;
  localparam int CMPW   = (LW > LEN_W) ? LW : LEN_W;
  localparam int PDEPTH = CHANNELS * PATTERN_DEPTH;
  localparam int AW     = $clog2(PDEPTH);
  localparam int CNT_W  = IVL_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMD   = 3'd1;
  localparam logic [2:0] ST_TRD   = 3'd2;
  localparam logic [2:0] ST_TPAT  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  typedef struct packed {
    logic             en;
    logic [LW-1:0]    len;
    logic [PW-1:0]    pos;
    logic [IVL_W-1:0] ivl;
    logic [IVL_W-1:0] cnt;
  } chan_st_t;

  localparam int SW = $bits(chan_st_t);

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  in_req_t           req_r, req_nxt;
  logic              pend_v_r, pend_v_nxt;
  out_res_t          pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_r, out_nxt;

  logic              st_re, st_we;
  logic [CW-1:0]     st_raddr, st_waddr;
  logic [SW-1:0]     st_rdata;
  chan_st_t          st_wdata;
  logic              pat_re, pat_we;
  logic [AW-1:0]     pat_raddr, pat_waddr;
  logic [DUTY_W-1:0] pat_rdata;

  chan_st_t          cur;
  chan_st_t          tick_st;
  chan_st_t          cmd_st;
  logic [CNT_W-1:0]  cnt_inc;
  logic              step;
  logic [PINC_W-1:0] pos_inc;
  logic [PW-1:0]     pos_new;
  logic [LW-1:0]     len_sat;
  logic              ch_ok, widx_ok;
  logic              out_free;
  logic              advance;
  logic              load_out;

  mlpp_state_mem #(
    .DEPTH (CHANNELS),
    .WIDTH (SW),
    .AW    (CW)
  ) u_state_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata)
  );

  mlpp_pattern_mem #(
    .DEPTH (PDEPTH),
    .AW    (AW)
  ) u_pattern_mem (
    .clk   (clk),
    .re    (pat_re),
    .raddr (pat_raddr),
    .rdata (pat_rdata),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (in_data.pattern_word)
  );

  // tick update of the channel just read
  always_comb begin
    cur     = chan_st_t'(st_rdata);
    cnt_inc = {1'b0, cur.cnt} + CNT_W'(1);
    step    = (cnt_inc >= {1'b0, cur.ivl});
    pos_inc = PINC_W'(cur.pos) + PINC_W'(1);
    if ((pos_inc >= PINC_W'(cur.len)) || (pos_inc >= PINC_W'(PATTERN_DEPTH))) begin
      pos_new = '0;
    end else begin
      pos_new = PW'(pos_inc);
    end
    tick_st = cur;
    if (step) begin
      tick_st.cnt = '0;
      tick_st.pos = pos_new;
    end else begin
      tick_st.cnt = cnt_inc[IVL_W-1:0];
    end
  end

  // length and interval settings
  always_comb begin
    if (CMPW'(req_r.seq_len) > CMPW'(PATTERN_DEPTH)) begin
      len_sat = LW'(PATTERN_DEPTH);
    end else begin
      len_sat = LW'(req_r.seq_len);
    end
    cmd_st = cur;
    if (req_r.cmd == CMD_LENGTH) begin
      if (req_r.seq_len == '0) begin
        cmd_st.en = 1'b0;
      end else begin
        cmd_st.en  = 1'b1;
        cmd_st.len = len_sat;
      end
    end else begin
      cmd_st.ivl = req_r.step_interval;
    end
  end

  assign ch_ok     = (32'(in_data.channel) < CHANNELS);
  assign widx_ok   = (32'(in_data.word_index) < PATTERN_DEPTH);
  assign out_free  = !out_valid_r || !out_stall;
  assign pat_waddr = AW'(in_data.channel) * AW'(PATTERN_DEPTH) + AW'(in_data.word_index);
  assign pat_raddr = AW'(idx_r) * AW'(PATTERN_DEPTH) + AW'(pos_new);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    st_re         = 1'b0;
    st_raddr      = idx_r;
    st_we         = 1'b0;
    st_waddr      = idx_r;
    st_wdata      = tick_st;
    pat_re        = 1'b0;
    pat_we        = 1'b0;
    advance       = 1'b0;
    load_out      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          unique case (in_data.cmd)
            CMD_TICK: begin
              idx_nxt    = '0;
              st_re      = 1'b1;
              st_raddr   = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_TRD;
            end
            CMD_WRITE: begin
              pat_we = ch_ok && widx_ok;
            end
            CMD_LENGTH, CMD_INTERVAL: begin
              if (ch_ok) begin
                st_re     = 1'b1;
                st_raddr  = CW'(in_data.channel);
                state_nxt = ST_CMD;
              end
            end
            CMD_DUTY: begin
              if (ch_ok) begin
                pend_nxt   = '{out_channel: in_data.channel,
                               out_duty: in_data.duty_value, last: 1'b1};
                pend_v_nxt = 1'b1;
                state_nxt  = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMD: begin
        st_we    = 1'b1;
        st_waddr = CW'(req_r.channel);
        st_wdata = cmd_st;
        if ((req_r.cmd == CMD_LENGTH) && (req_r.seq_len == '0)) begin
          pend_nxt   = '{out_channel: req_r.channel, out_duty: '0, last: 1'b1};
          pend_v_nxt = 1'b1;
          state_nxt  = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TRD: begin
        if (cur.en) begin
          st_we = 1'b1;
          if (step) begin
            pat_re    = 1'b1;
            state_nxt = ST_TPAT;
          end else begin
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ST_TPAT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            load_out      = 1'b1;
            out_nxt       = pend_r;
            out_nxt.last  = 1'b0;
            out_valid_nxt = 1'b1;
          end
          pend_nxt   = '{out_channel: CHAN_W'(idx_r), out_duty: pat_rdata, last: 1'b0};
          pend_v_nxt = 1'b1;
          advance    = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out      = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (idx_r == CW'(CHANNELS - 1)) begin
        state_nxt = ST_FLUSH;
      end else begin
        idx_nxt   = idx_r + CW'(1);
        st_re     = 1'b1;
        st_raddr  = idx_r + CW'(1);
        state_nxt = ST_TRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a state entry is never read and written back in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_re && st_we) |-> (st_raddr != st_waddr))
    else $error("state memory read and write collide");

  // the result register is only loaded once the previous result has been taken
  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // pattern data is only consumed after a tick state read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TPAT) |-> ($past(state_r) == ST_TRD || $past(state_r) == ST_TPAT))
    else $error("pattern stage entered without a state read");

  // no held-back result survives into idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("pending result lost at end of request");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED pattern player. Requests go in with random
// bursts and gaps while the result side stalls on its own pattern. Every
// accepted request updates a channel-level duty predictor held in a small
// scoreboard, and each accepted result is compared field by field with the
// oldest predicted duty change.
// ----------------------------------------------------------------------------
module testbench;
  import mlpp_pkg::*;

  localparam int CHANNELS       = 20;
  localparam int PATTERN_DEPTH  = 1024;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 60;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * CHANNELS + 8;
  localparam int MAX_REPORTS    = 10;

  class duty_scoreboard;
    logic              chan_on  [CHANNELS];
    logic [LEN_W-1:0]  chan_len [CHANNELS];
    logic [WIDX_W-1:0] chan_pos [CHANNELS];
    logic [IVL_W-1:0]  chan_ivl [CHANNELS];
    logic [IVL_W-1:0]  chan_cnt [CHANNELS];
    logic [DUTY_W-1:0] pattern  [CHANNELS*PATTERN_DEPTH];
    out_res_t          due_q[$];
    int unsigned       mismatches;

    function new();
      foreach (chan_on[i]) begin
        chan_on[i]  = 1'b0;
        chan_len[i] = '0;
        chan_pos[i] = '0;
        chan_ivl[i] = '0;
        chan_cnt[i] = '0;
      end
      mismatches = 0;
    endfunction

    function out_res_t duty_change(int unsigned ch, logic [DUTY_W-1:0] duty);
      out_res_t res;
      res.out_channel = ch[CHAN_W-1:0];
      res.out_duty    = duty;
      res.last        = 1'b0;
      return res;
    endfunction

    function void note_request(in_req_t r);
      out_res_t    batch[$];
      int unsigned ch;
      int unsigned nxt;
      int unsigned cnt;
      ch = r.channel;
      if (r.cmd == CMD_TICK) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_on[i]) begin
            cnt = chan_cnt[i] + 1;
            if (cnt >= chan_ivl[i]) begin
              chan_cnt[i] = '0;
              nxt = chan_pos[i] + 1;
              if (nxt >= chan_len[i] || nxt >= PATTERN_DEPTH) nxt = 0;
              chan_pos[i] = nxt[WIDX_W-1:0];
              batch.push_back(duty_change(i, pattern[i*PATTERN_DEPTH + nxt]));
            end else begin
              chan_cnt[i] = cnt[IVL_W-1:0];
            end
          end
        end
      end else if (r.cmd <= CMD_DUTY && ch < CHANNELS) begin
        case (r.cmd)
          CMD_WRITE: begin
            if (r.word_index < PATTERN_DEPTH)
              pattern[ch*PATTERN_DEPTH + r.word_index] = r.pattern_word;
          end
          CMD_LENGTH: begin
            if (r.seq_len == 0) begin
              chan_on[ch] = 1'b0;
              batch.push_back(duty_change(ch, '0));
            end else begin
              chan_len[ch] = (r.seq_len > PATTERN_DEPTH) ? LEN_W'(PATTERN_DEPTH)
                                                         : r.seq_len;
              chan_on[ch]  = 1'b1;
            end
          end
          CMD_INTERVAL: chan_ivl[ch] = r.step_interval;
          default: batch.push_back(duty_change(ch, r.duty_value));
        endcase
      end
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) due_q.push_back(batch[k]);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: channel %0d duty 0x%04h last %0b",
                   $time, got.out_channel, got.out_duty, got.last);
        return;
      end
      want = due_q.pop_front();
      if (got.out_channel !== want.out_channel || got.out_duty !== want.out_duty ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result mismatch: expected channel %0d duty 0x%04h last %0b, %s",
                   $time, want.out_channel, want.out_duty, want.last,
                   $sformatf("got channel %0d duty 0x%04h last %0b",
                             got.out_channel, got.out_duty, got.last));
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  duty_scoreboard sb = new();

  bit          word_seen [CHANNELS][PATTERN_DEPTH];
  int unsigned filled [CHANNELS];
  int unsigned burst_left;
  int unsigned taken;
  int unsigned hold_requests;
  int unsigned hold_served;

  multichannel_led_pattern_player #(
    .CHANNELS      (CHANNELS),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_req_t any_request();
    in_req_t r;
    r.cmd           = CMD_W'($urandom_range(0, 2**CMD_W - 1));
    r.channel       = CHAN_W'($urandom_range(0, 2**CHAN_W - 1));
    r.word_index    = WIDX_W'($urandom_range(0, 2**WIDX_W - 1));
    r.pattern_word  = DUTY_W'($urandom_range(0, 2**DUTY_W - 1));
    r.seq_len       = LEN_W'($urandom_range(0, 2**LEN_W - 1));
    r.step_interval = IVL_W'($urandom_range(0, 2**IVL_W - 1));
    r.duty_value    = DUTY_W'($urandom_range(0, 2**DUTY_W - 1));
    return r;
  endfunction

  task automatic issue(input in_req_t r);
    int unsigned need;
    if (r.cmd == CMD_LENGTH && r.channel < CHANNELS && r.seq_len != 0) begin
      need = (r.seq_len > PATTERN_DEPTH) ? PATTERN_DEPTH : r.seq_len;
      if (filled[r.channel] < need) begin
        need = (filled[r.channel] == 0) ? 0 : $urandom_range(1, filled[r.channel]);
        r.seq_len = need[LEN_W-1:0];
      end
    end
    if (r.cmd == CMD_WRITE && r.channel < CHANNELS) begin
      word_seen[r.channel][r.word_index] = 1'b1;
      while (filled[r.channel] < PATTERN_DEPTH && word_seen[r.channel][filled[r.channel]])
        filled[r.channel]++;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.cmd == CMD_TICK || (r.cmd <= CMD_DUTY && r.channel < CHANNELS)) taken++;
  endtask

  task automatic send(input logic [CMD_W-1:0] cmd, input int unsigned ch,
                      input int unsigned idx, input int unsigned value);
    in_req_t r;
    r = any_request();
    r.cmd     = cmd;
    r.channel = ch[CHAN_W-1:0];
    case (cmd)
      CMD_WRITE: begin
        r.word_index   = idx[WIDX_W-1:0];
        r.pattern_word = value[DUTY_W-1:0];
      end
      CMD_LENGTH:   r.seq_len       = value[LEN_W-1:0];
      CMD_INTERVAL: r.step_interval = value[IVL_W-1:0];
      CMD_DUTY:     r.duty_value    = value[DUTY_W-1:0];
      default: ;
    endcase
    issue(r);
  endtask

  task automatic pattern_sequence();
    int unsigned ch;
    int unsigned len;
    ch = $urandom_range(0, CHANNELS - 1);
    repeat ($urandom_range(0, 4))
      if (filled[ch] < PATTERN_DEPTH)
        send(CMD_WRITE, ch, filled[ch], $urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0)
      send(CMD_WRITE, ch, $urandom_range(0, PATTERN_DEPTH - 1), $urandom_range(0, 65535));
    send(CMD_INTERVAL, ch, 0, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 3));
    if (filled[ch] == 0 || $urandom_range(0, 5) == 0)
      len = 0;
    else if (filled[ch] == PATTERN_DEPTH && $urandom_range(0, 1) == 0)
      len = $urandom_range(1, 2**LEN_W - 1);
    else
      len = $urandom_range(1, filled[ch]);
    send(CMD_LENGTH, ch, 0, len);
    repeat ($urandom_range(1, 4)) send(CMD_TICK, $urandom_range(0, 31), 0, 0);
    if ($urandom_range(0, 3) == 0)
      send(CMD_DUTY, ch, 0, $urandom_range(0, 65535));
  endtask

  // receiver: random stall styles, with a long hold-off on request
  initial begin : result_sink
    int unsigned span;
    int unsigned style;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span  = $urandom_range(1, 40);
        style = $urandom_range(0, 3);
        for (int k = 0; k < span && hold_served == hold_requests; k++) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (k % 4 == 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(CMD_TICK, 0, 0, 0);
    send(CMD_DUTY, 0, 0, 16'hFFFF);
    send(CMD_DUTY, CHANNELS - 1, 0, 16'h0000);
    send(CMD_LENGTH, 5, 0, 0);
    send(CMD_WRITE, 0, 0, 16'hFFFF);
    send(CMD_WRITE, 0, 1, 16'h0000);
    send(CMD_WRITE, 0, PATTERN_DEPTH - 1, 16'hA5A5);
    send(CMD_INTERVAL, 0, 0, 0);
    send(CMD_LENGTH, 0, 0, 2);
    repeat (3) send(CMD_TICK, 31, 0, 0);
    send(CMD_DUTY, CHANNELS, 0, 16'h0001);
    send(CMD_WRITE, 31, 5, 16'h0001);
    for (int c = CMD_DUTY + 1; c < 2**CMD_W; c++) send(CMD_W'(c), 3, 0, 0);
    send(CMD_WRITE, 1, 0, 16'h1234);
    send(CMD_INTERVAL, 1, 0, 2);
    send(CMD_LENGTH, 1, 0, 1);
    repeat (3) send(CMD_TICK, 0, 0, 0);
    send(CMD_INTERVAL, 1, 0, 16'hFFFF);
    send(CMD_TICK, 0, 0, 0);
    send(CMD_LENGTH, 0, 0, 0);
    send(CMD_LENGTH, 1, 0, 0);

    // back-pressure: result side holds off while requests keep coming
    hold_requests++;
    burst_left = 20;
    repeat (12) send(CMD_DUTY, $urandom_range(0, CHANNELS - 1), 0, $urandom_range(0, 65535));
    send(CMD_TICK, 0, 0, 0);

    // random
    start = taken;
    while (taken - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7)
        pattern_sequence();
      else
        issue(any_request());
    end
    in_valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_q.size() != 0)
      $display("%0d predicted results never arrived", sb.due_q.size());
    if (sb.mismatches == 0 && sb.due_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== multichannel_led_pattern_player.f =====
rtl/core/mlpp_pkg.sv
rtl/core/mlpp_state_mem.sv
rtl/core/mlpp_pattern_mem.sv
rtl/core/multichannel_led_pattern_player.sv
dv/testbench.sv
